@@ src/ede_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types, codes and the microcode program of the edit distance engine.
// ----------------------------------------------------------------------------
package ede_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [3:0] op_type;
   typedef logic [2:0] cond_type;
   typedef logic [3:0] step_type;

   localparam mode_type MODE_LOAD_FIRST  = 2'd0;
   localparam mode_type MODE_LOAD_SECOND = 2'd1;
   localparam mode_type MODE_COMPUTE     = 2'd2;

   localparam logic [7:0] THRESHOLD_RESET = 8'd8;
   localparam logic [1:0] SUBST_COST      = 2'd2;
   localparam logic [7:0] CAP             = 8'd255;

   // datapath operations
   localparam op_type OP_NOP       = 4'd0;
   localparam op_type OP_SETUP     = 4'd1;
   localparam op_type OP_INIT_ROW  = 4'd2;
   localparam op_type OP_NEXT_ROW  = 4'd3;
   localparam op_type OP_ROW_SETUP = 4'd4;
   localparam op_type OP_CELL      = 4'd5;
   localparam op_type OP_OUT_DONE  = 4'd6;
   localparam op_type OP_OUT_EARLY = 4'd7;
   localparam op_type OP_OUT_EMPTY = 4'd8;

   // branch conditions
   localparam cond_type COND_NONE      = 3'd0;
   localparam cond_type COND_ALWAYS    = 3'd1;
   localparam cond_type COND_WAIT_GO   = 3'd2;
   localparam cond_type COND_RLEN_ZERO = 3'd3;
   localparam cond_type COND_J_MORE    = 3'd4;
   localparam cond_type COND_OVER_THR  = 3'd5;
   localparam cond_type COND_I_MORE    = 3'd6;

   // program steps
   localparam step_type STEP_IDLE      = 4'd0;
   localparam step_type STEP_CHECK     = 4'd1;
   localparam step_type STEP_INIT      = 4'd2;
   localparam step_type STEP_ROW_START = 4'd3;
   localparam step_type STEP_ROW_SETUP = 4'd4;
   localparam step_type STEP_CELL      = 4'd5;
   localparam step_type STEP_ROW_END   = 4'd6;
   localparam step_type STEP_ROW_NEXT  = 4'd7;
   localparam step_type STEP_DONE      = 4'd8;
   localparam step_type STEP_EARLY     = 4'd9;
   localparam step_type STEP_EMPTY     = 4'd10;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic rlen_zero;
      logic j_more;
      logic i_more;
      logic over_thr;
   } status_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      case (step)
         STEP_IDLE:      word = '{OP_SETUP,     COND_WAIT_GO,   STEP_IDLE};
         STEP_CHECK:     word = '{OP_NOP,       COND_RLEN_ZERO, STEP_EMPTY};
         STEP_INIT:      word = '{OP_INIT_ROW,  COND_J_MORE,    STEP_INIT};
         STEP_ROW_START: word = '{OP_NEXT_ROW,  COND_NONE,      STEP_IDLE};
         STEP_ROW_SETUP: word = '{OP_ROW_SETUP, COND_NONE,      STEP_IDLE};
         STEP_CELL:      word = '{OP_CELL,      COND_J_MORE,    STEP_CELL};
         STEP_ROW_END:   word = '{OP_NOP,       COND_OVER_THR,  STEP_EARLY};
         STEP_ROW_NEXT:  word = '{OP_NOP,       COND_I_MORE,    STEP_ROW_START};
         STEP_DONE:      word = '{OP_OUT_DONE,  COND_ALWAYS,    STEP_IDLE};
         STEP_EARLY:     word = '{OP_OUT_EARLY, COND_ALWAYS,    STEP_IDLE};
         STEP_EMPTY:     word = '{OP_OUT_EMPTY, COND_ALWAYS,    STEP_IDLE};
         default:        word = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
      endcase
      return word;
   endfunction

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {7'd0, b};
      return sum[8] ? CAP : sum[7:0];
   endfunction

endpackage

@@ src/edit_distance_early_exit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_early_exit
// Weighted edit distance of two loaded byte strings with a row-minimum exit.
// ----------------------------------------------------------------------------
// Load beats (mode 0 or 1) are taken one per cycle while busy is low and give
// no result. A compute beat holds busy high while a microcoded sequencer walks
// the table one cell per cycle through a single row memory, a row per byte of
// the longer string; it stops on an early exit and skips the table when a
// string is empty. The result then appears for one cycle on rsp_strobe; the
// receiver cannot stall it, so it must be taken then.
module edit_distance_early_exit #(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_char_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_distance,
   output logic       rsp_early_exit,
   output logic       rsp_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [LW-1:0] first_len_ff, first_len_in, second_len_ff, second_len_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    threshold_ff;
   logic          accept, go;
   logic          wr_first, wr_second;
   logic [AW-1:0] wr_addr;

   ede_pkg::op_type     op;
   ede_pkg::status_type status;

   assign accept    = start && !busy;
   assign go        = accept && (req_mode == ede_pkg::MODE_COMPUTE);
   assign csr_ready = !busy;

   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      ovf_in        = ovf_ff;
      wr_first      = 1'b0;
      wr_second     = 1'b0;
      wr_addr       = AW'(first_len_ff);
      if (accept) begin
         case (req_mode)
            ede_pkg::MODE_LOAD_FIRST: begin
               if (first_len_ff < LW'(MAX_LEN)) begin
                  wr_first     = 1'b1;
                  first_len_in = first_len_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            ede_pkg::MODE_LOAD_SECOND: begin
               wr_addr = AW'(second_len_ff);
               if (second_len_ff < LW'(MAX_LEN)) begin
                  wr_second     = 1'b1;
                  second_len_in = second_len_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            ede_pkg::MODE_COMPUTE: begin
               first_len_in  = '0;
               second_len_in = '0;
               ovf_in        = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
         threshold_ff  <= ede_pkg::THRESHOLD_RESET;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_ff        <= ovf_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
      end
   end

   ede_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   ede_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .wr_first       (wr_first),
      .wr_second      (wr_second),
      .wr_addr        (wr_addr),
      .wr_data        (req_char_byte),
      .first_len      (first_len_ff),
      .second_len     (second_len_ff),
      .overflow_seen  (ovf_ff),
      .threshold      (threshold_ff),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_distance   (rsp_distance),
      .rsp_early_exit (rsp_early_exit),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

@@ src/ede_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_sequencer
// Step counter over the microcode table with conditional branching.
// ----------------------------------------------------------------------------
module ede_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  ede_pkg::status_type    status,
   output ede_pkg::op_type        op,
   output logic                   busy
);

   ede_pkg::step_type  pc_ff;
   ede_pkg::step_type  pc_in;
   ede_pkg::ucode_type word;
   logic               taken;

   always_comb begin
      word = ede_pkg::ucode_rom(pc_ff);
      case (word.cond)
         ede_pkg::COND_NONE:      taken = 1'b0;
         ede_pkg::COND_ALWAYS:    taken = 1'b1;
         ede_pkg::COND_WAIT_GO:   taken = !go;
         ede_pkg::COND_RLEN_ZERO: taken = status.rlen_zero;
         ede_pkg::COND_J_MORE:    taken = status.j_more;
         ede_pkg::COND_OVER_THR:  taken = status.over_thr;
         ede_pkg::COND_I_MORE:    taken = status.i_more;
         default:                 taken = 1'b1;
      endcase
      pc_in = taken ? word.target : pc_ff + 4'd1;
      // waiting step runs its operation only on the start beat
      op = (word.cond == ede_pkg::COND_WAIT_GO && !go) ? ede_pkg::OP_NOP : word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ede_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign busy = (pc_ff != ede_pkg::STEP_IDLE);

endmodule

@@ src/ede_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_datapath
// String and row memories, cell update and result registers.
// ----------------------------------------------------------------------------
module ede_datapath #(
   parameter int MAX_LEN = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ede_pkg::op_type                      op,
   input  logic                                 wr_first,
   input  logic                                 wr_second,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
   input  logic [7:0]                           wr_data,
   input  logic [$clog2(MAX_LEN+1)-1:0]         first_len,
   input  logic [$clog2(MAX_LEN+1)-1:0]         second_len,
   input  logic                                 overflow_seen,
   input  logic [7:0]                           threshold,
   output ede_pkg::status_type                  status,
   output logic                                 rsp_strobe,
   output logic [7:0]                           rsp_distance,
   output logic                                 rsp_early_exit,
   output logic                                 rsp_overflow
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int JW = $clog2(MAX_LEN + 2);
   localparam int RW = $clog2(MAX_LEN + 1);

   logic [7:0] first_mem  [0:MAX_LEN-1];
   logic [7:0] second_mem [0:MAX_LEN-1];
   logic [7:0] row_mem    [0:MAX_LEN];

   logic [7:0]    first_rd_ff, second_rd_ff, row_rd_ff;
   logic          swap_ff, swap_in;
   logic [LW-1:0] rlen_ff, rlen_in, clen_ff, clen_in, i_ff, i_in;
   logic [JW-1:0] j_ff, j_in;
   logic [7:0]    diag_ff, diag_in, left_ff, left_in, lowest_ff, lowest_in;
   logic [7:0]    col_char_ff, col_char_in;
   logic          ovf_ff, ovf_in;
   logic          strobe_ff, strobe_in;
   logic [7:0]    dist_ff, dist_in;
   logic          early_ff, early_in;
   logic          out_ovf_ff, out_ovf_in;

   logic          row_we;
   logic [7:0]    row_wdata;
   logic [AW-1:0] rs_addr, cs_addr;
   logic [7:0]    row_char, col_rd;
   logic [7:0]    best, del_cost, ins_cost;
   logic [1:0]    sub_cost;

   assign row_char = swap_ff ? second_rd_ff : first_rd_ff;
   assign col_rd   = swap_ff ? first_rd_ff  : second_rd_ff;

   // cell update
   always_comb begin
      sub_cost = (row_char == col_char_ff) ? 2'd0 : ede_pkg::SUBST_COST;
      best     = ede_pkg::sat_add(diag_ff, sub_cost);
      del_cost = ede_pkg::sat_add(row_rd_ff, 2'd1);
      ins_cost = ede_pkg::sat_add(left_ff, 2'd1);
      if (del_cost < best) begin
         best = del_cost;
      end
      if (ins_cost < best) begin
         best = ins_cost;
      end
   end

   always_comb begin
      swap_in     = swap_ff;
      rlen_in     = rlen_ff;
      clen_in     = clen_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      diag_in     = diag_ff;
      left_in     = left_ff;
      lowest_in   = lowest_ff;
      col_char_in = col_char_ff;
      ovf_in      = ovf_ff;
      strobe_in   = 1'b0;
      dist_in     = dist_ff;
      early_in    = early_ff;
      out_ovf_in  = out_ovf_ff;
      row_we      = 1'b0;
      row_wdata   = best;
      case (op)
         ede_pkg::OP_SETUP: begin
            swap_in = (first_len > second_len);
            rlen_in = swap_in ? second_len : first_len;
            clen_in = swap_in ? first_len : second_len;
            i_in    = '0;
            j_in    = '0;
            ovf_in  = overflow_seen;
         end
         ede_pkg::OP_INIT_ROW: begin
            row_we    = 1'b1;
            row_wdata = 8'(j_ff);
            j_in      = j_ff + JW'(1);
         end
         ede_pkg::OP_NEXT_ROW: begin
            i_in = i_ff + LW'(1);
            j_in = '0;
         end
         ede_pkg::OP_ROW_SETUP: begin
            diag_in     = row_rd_ff;
            col_char_in = col_rd;
            left_in     = 8'(i_ff);
            lowest_in   = 8'(i_ff);
            row_we      = 1'b1;
            row_wdata   = 8'(i_ff);
            j_in        = JW'(1);
         end
         ede_pkg::OP_CELL: begin
            row_we    = 1'b1;
            row_wdata = best;
            left_in   = best;
            diag_in   = row_rd_ff;
            lowest_in = (best < lowest_ff) ? best : lowest_ff;
            j_in      = j_ff + JW'(1);
         end
         ede_pkg::OP_OUT_DONE: begin
            strobe_in  = 1'b1;
            dist_in    = left_ff;
            early_in   = 1'b0;
            out_ovf_in = ovf_ff;
         end
         ede_pkg::OP_OUT_EARLY: begin
            strobe_in  = 1'b1;
            dist_in    = lowest_ff;
            early_in   = 1'b1;
            out_ovf_in = ovf_ff;
         end
         ede_pkg::OP_OUT_EMPTY: begin
            strobe_in  = 1'b1;
            dist_in    = 8'(clen_ff);
            early_in   = 1'b0;
            out_ovf_in = ovf_ff;
         end
         default: begin
         end
      endcase
   end

   // read addresses use the next index values, matching the index registers
   assign rs_addr = AW'(j_in - JW'(1));
   assign cs_addr = AW'(i_in - LW'(1));

   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_mem[wr_addr] <= wr_data;
      end
      if (wr_second) begin
         second_mem[wr_addr] <= wr_data;
      end
      first_rd_ff  <= first_mem[swap_ff ? cs_addr : rs_addr];
      second_rd_ff <= second_mem[swap_ff ? rs_addr : cs_addr];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[j_ff[RW-1:0]] <= row_wdata;
      end
      row_rd_ff <= row_mem[j_in[RW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      swap_ff     <= swap_in;
      rlen_ff     <= rlen_in;
      clen_ff     <= clen_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      lowest_ff   <= lowest_in;
      col_char_ff <= col_char_in;
      ovf_ff      <= ovf_in;
      dist_ff     <= dist_in;
      early_ff    <= early_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign status.rlen_zero = (rlen_ff == '0);
   assign status.j_more    = (j_ff != JW'(rlen_ff));
   assign status.i_more    = (i_ff != clen_ff);
   assign status.over_thr  = (lowest_ff > threshold);

   assign rsp_strobe     = strobe_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_early_exit = early_ff;
   assign rsp_overflow   = out_ovf_ff;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the edit distance engine with early exit.
// ----------------------------------------------------------------------------
// A directed table covers the following cases:
//   - empty strings
//   - the ignored mode
//   - single matching and mismatching bytes
//   - strings that fill up and overflow
//   - the largest table
//   - the threshold exit
// Random phases then load mostly short strings drawn from small alphabets and
// compute. Each phase has its own threshold, including both extremes, and its
// own sender gap rate. Every result is checked against a dynamic programming
// model of the weighted edit distance kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_LEN      = 64;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1350;
   localparam int PHASES       = 6;
   localparam int ROWS         = 33;
   localparam ede_pkg::mode_type MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] distance;
      logic       early_exit;
      logic       overflow;
   } edit_result_type;

   typedef struct {
      ede_pkg::mode_type mode;
      logic [7:0]        value;
      int                count;
      bit                given;
      logic [7:0]        distance;
      logic              early_exit;
      logic              overflow;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ede_pkg::mode_type req_mode = ede_pkg::MODE_LOAD_FIRST;
   logic [7:0]        req_char_byte = 8'd0;
   logic              rsp_strobe;
   logic [7:0]        rsp_distance;
   logic              rsp_early_exit;
   logic              rsp_overflow;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_data = 8'd0;

   // shadow state of the engine
   logic [7:0] first_chars [MAX_LEN];
   logic [7:0] second_chars [MAX_LEN];
   int         first_len = 0;
   int         second_len = 0;
   logic       overflow_seen = 1'b0;
   logic [7:0] threshold = ede_pkg::THRESHOLD_RESET;

   edit_result_type expected_results [$];
   bit              given_valid = 1'b0;
   edit_result_type given_result = '0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              idle_pct = 0;

   // mode, byte, repeat, given, distance, early_exit, overflow
   stim_row_type directed_rows [ROWS] = '{
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd0,  1'b0, 1'b0},
      '{MODE_UNUSED,               8'hFF,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'hFF,  1, 1'b1, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_FIRST,  8'h00,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd1,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'hFF,  2, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd2,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_FIRST,  8'hA5,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'hA5,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_FIRST,  8'h55,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'hAA,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd2,  1'b0, 1'b0},
      // first string overflows, second empty
      '{ede_pkg::MODE_LOAD_FIRST,  8'h5A, 65, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd64, 1'b0, 1'b1},
      '{ede_pkg::MODE_LOAD_SECOND, 8'hC3, 66, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd64, 1'b0, 1'b1},
      // full table, identical strings
      '{ede_pkg::MODE_LOAD_FIRST,  8'h11, 64, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'h11, 64, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd0,  1'b0, 1'b0},
      // all mismatches: row minimum passes the reset threshold on row 9
      '{ede_pkg::MODE_LOAD_FIRST,  8'h11, 64, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'hEE, 64, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd9,  1'b1, 1'b0},
      '{ede_pkg::MODE_LOAD_FIRST,  8'h01, 65, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'hFE, 65, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b1, 8'd9,  1'b1, 1'b1},
      // second string shorter
      '{ede_pkg::MODE_LOAD_FIRST,  8'h41,  5, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'h41,  2, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_FIRST,  8'h7E,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{MODE_UNUSED,               8'h80,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_LOAD_SECOND, 8'h7F,  1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{ede_pkg::MODE_COMPUTE,     8'h00,  1, 1'b0, 8'd0,  1'b0, 1'b0}
   };

   logic [7:0] phase_threshold [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd5, 8'd0};
   int         phase_idle [PHASES] = '{0, 83, 14, 83, 0, 14};

   edit_distance_early_exit #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_char_byte(req_char_byte),
      .rsp_strobe(rsp_strobe),
      .rsp_distance(rsp_distance),
      .rsp_early_exit(rsp_early_exit),
      .rsp_overflow(rsp_overflow),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] capped(input int v);
      return (v > 255) ? ede_pkg::CAP : v[7:0];
   endfunction

   function automatic edit_result_type predict_distance();
      edit_result_type res;
      logic [7:0]      prev_row [MAX_LEN + 1];
      logic [7:0]      this_row [MAX_LEN + 1];
      logic [7:0]      lowest, best, del_cost, ins_cost, row_char, col_char;
      bit              swap;
      int              rlen, clen, i, j;
      res.distance = 8'd0;
      res.early_exit = 1'b0;
      res.overflow = overflow_seen;
      // the shorter string indexes the row, the first one on a tie
      swap = first_len > second_len;
      rlen = swap ? second_len : first_len;
      clen = swap ? first_len : second_len;
      if (rlen == 0) begin
         res.distance = capped(clen);
         return res;
      end
      for (j = 0; j <= rlen; j++) prev_row[j] = capped(j);
      for (i = 1; i <= clen; i++) begin
         this_row[0] = capped(i);
         lowest = this_row[0];
         for (j = 1; j <= rlen; j++) begin
            row_char = swap ? second_chars[j - 1] : first_chars[j - 1];
            col_char = swap ? first_chars[i - 1] : second_chars[i - 1];
            best = capped(int'(prev_row[j - 1]) +
                          ((row_char == col_char) ? 0 : int'(ede_pkg::SUBST_COST)));
            del_cost = capped(int'(prev_row[j]) + 1);
            ins_cost = capped(int'(this_row[j - 1]) + 1);
            if (del_cost < best) best = del_cost;
            if (ins_cost < best) best = ins_cost;
            this_row[j] = best;
            if (best < lowest) lowest = best;
         end
         if (lowest > threshold) begin
            res.distance = lowest;
            res.early_exit = 1'b1;
            return res;
         end
         prev_row = this_row;
      end
      res.distance = prev_row[rlen];
      return res;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      edit_result_type seen, want;
      if (!reset) begin
         if (rsp_strobe) begin
            seen = '{rsp_distance, rsp_early_exit, rsp_overflow};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: distance %0d early_exit %0b overflow %0b",
                           seen.distance, seen.early_exit, seen.overflow);
            end else begin
               want = expected_results.pop_front();
               if (seen.distance !== want.distance || seen.early_exit !== want.early_exit ||
                   seen.overflow !== want.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: distance %0d/%0d early_exit %0b/%0b overflow %0b/%0b",
                              seen.distance, want.distance, seen.early_exit, want.early_exit,
                              seen.overflow, want.overflow);
               end
            end
         end
         if (csr_valid && csr_ready) threshold = csr_data;
         if (start && !busy) begin
            case (req_mode)
               ede_pkg::MODE_LOAD_FIRST: begin
                  if (first_len < MAX_LEN) begin
                     first_chars[first_len] = req_char_byte;
                     first_len++;
                  end else begin
                     overflow_seen = 1'b1;
                  end
               end
               ede_pkg::MODE_LOAD_SECOND: begin
                  if (second_len < MAX_LEN) begin
                     second_chars[second_len] = req_char_byte;
                     second_len++;
                  end else begin
                     overflow_seen = 1'b1;
                  end
               end
               ede_pkg::MODE_COMPUTE: begin
                  expected_results.push_back(given_valid ? given_result : predict_distance());
                  first_len = 0;
                  second_len = 0;
                  overflow_seen = 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   task automatic send_item(input ede_pkg::mode_type mode, input logic [7:0] value,
                            input bit given, input edit_result_type result);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      given_valid = given;
      given_result = result;
      start <= 1'b1;
      req_mode <= mode;
      req_char_byte <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain(input int tail);
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0]        alphabet [4];
      logic [7:0]        value;
      ede_pkg::mode_type pick_mode;
      int                row, n, phase, sent, la, lb, k;
      phase_threshold[3] = 8'($urandom_range(255));
      phase_threshold[5] = 8'($urandom_range(255));
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < ROWS; row++) begin
         for (n = 0; n < directed_rows[row].count; n++)
            send_item(directed_rows[row].mode, directed_rows[row].value,
                      directed_rows[row].given,
                      '{directed_rows[row].distance, directed_rows[row].early_exit,
                        directed_rows[row].overflow});
      end

      for (phase = 0; phase < PHASES; phase++) begin
         drain(8);
         write_threshold(phase_threshold[phase]);
         idle_pct = phase_idle[phase];
         sent = 0;
         while (sent < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(99) < 8) begin
               // stray beat of any mode
               pick_mode = 2'($urandom_range(3));
               send_item(pick_mode, 8'($urandom_range(255)), 1'b0, '0);
               if (pick_mode != MODE_UNUSED) sent++;
            end else begin
               if ($urandom_range(99) < 3) begin
                  la = $urandom_range(40, 70);
                  lb = $urandom_range(40, 70);
               end else begin
                  la = $urandom_range(0, 8);
                  lb = $urandom_range(0, 8);
               end
               for (k = 0; k < 4; k++) alphabet[k] = 8'($urandom_range(255));
               while (la + lb > 0) begin
                  value = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                   : alphabet[2'($urandom_range(3))];
                  if ($urandom_range(19) == 0) send_item(MODE_UNUSED, value, 1'b0, '0);
                  if (lb == 0 || (la > 0 && $urandom_range(1) == 0)) begin
                     send_item(ede_pkg::MODE_LOAD_FIRST, value, 1'b0, '0);
                     la--;
                  end else begin
                     send_item(ede_pkg::MODE_LOAD_SECOND, value, 1'b0, '0);
                     lb--;
                  end
                  sent++;
               end
               // now and then the compute is left out and the strings run on
               if ($urandom_range(19) != 0) begin
                  send_item(ede_pkg::MODE_COMPUTE, 8'($urandom_range(255)), 1'b0, '0);
                  sent++;
               end
            end
         end
      end

      drain(200);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
